@@ hw/rtl/spg_pkg.sv @@
package spg_pkg;

  // Frame shape
  localparam int PACKET_CHANNELS = 9;
  localparam int PPM_SLOTS       = 8;
  localparam int SERVO_OUTPUTS   = 8;
  localparam int SKIPPED_SLOT    = 7;

  localparam int MAX_SLOTS = (PPM_SLOTS > SERVO_OUTPUTS) ? PPM_SLOTS : SERVO_OUTPUTS;
  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int BIDX_W    = $clog2(2 * PACKET_CHANNELS);

  // Packet framing bytes
  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] TRL_BYTE = 8'hEE;

  // Request opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Register file
  localparam int          CFG_AW        = 4;
  localparam logic [1:0]  REG_MODE      = 2'd0;
  localparam logic [1:0]  REG_PRE       = 2'd1;
  localparam logic [1:0]  REG_GAP       = 2'd2;
  localparam logic        MODE_PPM      = 1'b0;
  localparam logic [15:0] PRE_PULSE_RST = 16'd2949;
  localparam logic [15:0] SYNC_GAP_RST  = 16'd30966;

  // Request queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [PACKET_CHANNELS-1:0][15:0] chan_vals_t;

  typedef enum logic [5:0] {
    G_IDLE     = 6'b000001,
    G_PRE      = 6'b000010,
    G_CHAN     = 6'b000100,
    G_SYNC_PRE = 6'b001000,
    G_SYNC_GAP = 6'b010000,
    G_PWM      = 6'b100000
  } gen_phase_t;

  typedef struct packed {
    logic       is_tick;
    logic       is_hdr;
    logic       is_trl;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] pre;
    logic [15:0] gap;
  } cfg_t;

  typedef struct packed {
    gen_phase_t        phase;
    logic [SLOT_W-1:0] slot;
  } gen_pos_t;

  // Channel time of a slot; slots past the packet read as zero
  function automatic logic [15:0] slot_value(chan_vals_t vals, logic [SLOT_W-1:0] slot);
    logic [15:0] v;
    v = '0;
    for (int i = 0; i < PACKET_CHANNELS; i++) begin
      if (int'(slot) == i) begin
        v = vals[i];
      end
    end
    return v;
  endfunction

  function automatic logic [15:0] phase_len(gen_pos_t p, chan_vals_t vals, cfg_t cfg);
    logic [15:0] v;
    logic [15:0] len;
    v = slot_value(vals, p.slot);
    len = '0;
    case (p.phase)
      G_PRE, G_SYNC_PRE: len = cfg.pre;
      G_CHAN:            len = (v > cfg.pre) ? v - cfg.pre : '0;
      G_SYNC_GAP:        len = cfg.gap;
      G_PWM:             len = v;
      default:           len = '0;
    endcase
    return len;
  endfunction

  // Phase that follows p in the frame sequence
  function automatic gen_pos_t next_pos(gen_pos_t p);
    gen_pos_t r;
    r.phase = G_IDLE;
    r.slot  = '0;
    case (p.phase)
      G_PRE: begin
        r.phase = G_CHAN;
        r.slot  = p.slot;
      end
      G_CHAN: begin
        if (int'(p.slot) + 1 < PPM_SLOTS) begin
          r.phase = G_PRE;
          r.slot  = SLOT_W'(int'(p.slot) + 1);
        end else begin
          r.phase = G_SYNC_PRE;
        end
      end
      G_SYNC_PRE: r.phase = G_SYNC_GAP;
      G_PWM: begin
        if (int'(p.slot) + 1 < SERVO_OUTPUTS) begin
          r.phase = G_PWM;
          r.slot  = SLOT_W'(int'(p.slot) + 1);
        end
      end
      default: r.phase = G_IDLE;
    endcase
    return r;
  endfunction

  // First phase at or after cand with a nonzero length. With a nonzero
  // pre-pulse only one channel phase can be skipped; with a zero pre-pulse
  // all pre-pulses vanish and a priority search finds the next live channel.
  function automatic gen_pos_t resolve_pos(gen_pos_t cand, chan_vals_t vals, cfg_t cfg);
    logic [PPM_SLOTS-1:0]     chan_nz;
    logic [SERVO_OUTPUTS-1:0] pwm_nz;
    logic                     pre_nz;
    logic                     gap_nz;
    logic                     c_found;
    logic                     p_found;
    logic [SLOT_W-1:0]        c_slot;
    logic [SLOT_W-1:0]        p_slot;
    gen_pos_t                 r;
    pre_nz  = (cfg.pre != '0);
    gap_nz  = (cfg.gap != '0);
    c_found = 1'b0;
    p_found = 1'b0;
    c_slot  = '0;
    p_slot  = '0;
    for (int s = 0; s < PPM_SLOTS; s++) begin
      chan_nz[s] = slot_value(vals, SLOT_W'(s)) > cfg.pre;
    end
    for (int s = 0; s < SERVO_OUTPUTS; s++) begin
      pwm_nz[s] = slot_value(vals, SLOT_W'(s)) != '0;
    end
    for (int s = 0; s < PPM_SLOTS; s++) begin
      if (!c_found && s >= int'(cand.slot) && chan_nz[s]) begin
        c_found = 1'b1;
        c_slot  = SLOT_W'(s);
      end
    end
    for (int s = 0; s < SERVO_OUTPUTS; s++) begin
      if (!p_found && s >= int'(cand.slot) && pwm_nz[s]) begin
        p_found = 1'b1;
        p_slot  = SLOT_W'(s);
      end
    end
    r.phase = G_IDLE;
    r.slot  = '0;
    case (cand.phase)
      G_PRE, G_CHAN: begin
        if (pre_nz) begin
          if (cand.phase == G_PRE) begin
            r = cand;
          end else if (chan_nz[cand.slot]) begin
            r = cand;
          end else if (int'(cand.slot) + 1 < PPM_SLOTS) begin
            r.phase = G_PRE;
            r.slot  = SLOT_W'(int'(cand.slot) + 1);
          end else begin
            r.phase = G_SYNC_PRE;
          end
        end else if (c_found) begin
          r.phase = G_CHAN;
          r.slot  = c_slot;
        end else if (gap_nz) begin
          r.phase = G_SYNC_GAP;
        end
      end
      G_SYNC_PRE: begin
        if (pre_nz) begin
          r.phase = G_SYNC_PRE;
        end else if (gap_nz) begin
          r.phase = G_SYNC_GAP;
        end
      end
      G_SYNC_GAP: begin
        if (gap_nz) begin
          r.phase = G_SYNC_GAP;
        end
      end
      G_PWM: begin
        if (p_found) begin
          r.phase = G_PWM;
          r.slot  = p_slot;
        end
      end
      default: r.phase = G_IDLE;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/spg_front.sv @@
module spg_front
  import spg_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [7:0] in_rx_byte,
  input  logic       q_full,
  output logic       push,
  output item_t      push_item
);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Pre-decode the framing bytes so the back end only sees flags
  always_comb begin
    push_item.is_tick = (in_opcode == OP_TICK);
    push_item.is_hdr  = (in_opcode == OP_BYTE) && (in_rx_byte == HDR_BYTE);
    push_item.is_trl  = (in_opcode == OP_BYTE) && (in_rx_byte == TRL_BYTE);
    push_item.rx_byte = in_rx_byte;
  end

endmodule

@@ hw/rtl/spg_queue.sv @@
module spg_queue
  import spg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  q_full,
  output logic  q_valid,
  output item_t q_item,
  input  logic  pop
);

  item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;

  assign q_full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == Q_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == Q_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/spg_back.sv @@
module spg_back
  import spg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_ppm_level,
  output logic [7:0] out_servo_levels,
  output logic       out_frame_active,
  output logic       out_packet_ok
);

  typedef enum logic [3:0] {
    P_START    = 4'b0001,
    P_PREAMBLE = 4'b0010,
    P_PACKET   = 4'b0100,
    P_VERIFY   = 4'b1000
  } parse_phase_t;

  parse_phase_t      pphase_r;
  parse_phase_t      pphase_nxt;
  logic [BIDX_W-1:0] bidx_r;
  logic [BIDX_W-1:0] bidx_nxt;
  chan_vals_t        pending_r;
  chan_vals_t        pending_nxt;
  logic              pvalid_r;
  logic              pvalid_nxt;
  chan_vals_t        active_r;
  chan_vals_t        active_nxt;
  gen_pos_t          pos_r;
  gen_pos_t          pos_nxt;
  logic [15:0]       tick_r;
  logic [15:0]       tick_nxt;

  logic              ok;
  logic              parsed_valid;
  gen_pos_t          tick_pos;
  logic [15:0]       tick_cnt;
  logic [15:0]       tick_inc;
  gen_pos_t          step_pos;
  gen_pos_t          start_cand;
  gen_pos_t          start_pos;
  logic [7:0]        servo;

  logic              out_valid_r;
  logic              ppm_r;
  logic [7:0]        servo_r;
  logic              active_flag_r;
  logic              ok_r;

  assign pop = q_valid && (!out_valid_r || out_ready);

  // Packet deframer
  always_comb begin
    pphase_nxt   = pphase_r;
    bidx_nxt     = bidx_r;
    pending_nxt  = pending_r;
    parsed_valid = pvalid_r;
    ok           = 1'b0;
    if (!q_item.is_tick) begin
      case (pphase_r)
        P_START: begin
          if (q_item.is_hdr) pphase_nxt = P_PREAMBLE;
        end
        P_PREAMBLE: begin
          if (q_item.is_hdr) begin
            pphase_nxt = P_PACKET;
            bidx_nxt   = '0;
          end else begin
            pphase_nxt = P_START;
          end
        end
        P_PACKET: begin
          for (int i = 0; i < PACKET_CHANNELS; i++) begin
            if ((int'(bidx_r) >> 1) == i) begin
              if (!bidx_r[0]) pending_nxt[i][15:8] = q_item.rx_byte;
              else            pending_nxt[i][7:0]  = q_item.rx_byte;
            end
          end
          parsed_valid = 1'b0;
          if (int'(bidx_r) == 2 * PACKET_CHANNELS - 1) begin
            pphase_nxt = P_VERIFY;
            bidx_nxt   = '0;
          end else begin
            bidx_nxt = bidx_r + 1'b1;
          end
        end
        P_VERIFY: begin
          if (q_item.is_trl) begin
            parsed_valid = 1'b1;
            ok           = 1'b1;
          end
          pphase_nxt = P_START;
        end
        default: pphase_nxt = P_START;
      endcase
    end
  end

  // Frame sequencer. A new frame only starts when pending is set, and the
  // byte or tick that sets it never writes pending data, so pending_r is
  // already the data to latch.
  assign tick_inc   = tick_r + 16'd1;
  assign start_cand = '{phase: (cfg.mode == MODE_PPM) ? G_PRE : G_PWM, slot: '0};
  assign start_pos  = resolve_pos(start_cand, pending_r, cfg);

  always_comb begin
    tick_pos = pos_r;
    tick_cnt = tick_r;
    if (q_item.is_tick && pos_r.phase != G_IDLE) begin
      tick_cnt = tick_inc;
      if (tick_inc >= phase_len(pos_r, active_r, cfg)) begin
        tick_pos = resolve_pos(next_pos(pos_r), active_r, cfg);
        tick_cnt = '0;
      end
    end
  end

  always_comb begin
    step_pos   = tick_pos;
    tick_nxt   = tick_cnt;
    active_nxt = active_r;
    pvalid_nxt = parsed_valid;
    if (tick_pos.phase == G_IDLE && parsed_valid) begin
      active_nxt = pending_r;
      pvalid_nxt = 1'b0;
      step_pos   = start_pos;
      tick_nxt   = '0;
    end
    pos_nxt = step_pos;
  end

  // Pin levels after this request
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      servo[b] = 1'b0;
      if (b < SERVO_OUTPUTS && int'(step_pos.slot) == b) begin
        if (step_pos.phase == G_PWM) begin
          servo[b] = 1'b1;
        end else if ((step_pos.phase == G_PRE || step_pos.phase == G_CHAN)
                     && b != SKIPPED_SLOT) begin
          servo[b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pphase_r    <= P_START;
      bidx_r      <= '0;
      pending_r   <= '0;
      pvalid_r    <= 1'b0;
      active_r    <= '0;
      pos_r       <= '{phase: G_IDLE, slot: '0};
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        pphase_r  <= pphase_nxt;
        bidx_r    <= bidx_nxt;
        pending_r <= pending_nxt;
        pvalid_r  <= pvalid_nxt;
        active_r  <= active_nxt;
        pos_r     <= pos_nxt;
        tick_r    <= tick_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ppm_r         <= (step_pos.phase == G_PRE) || (step_pos.phase == G_SYNC_PRE);
      servo_r       <= servo;
      active_flag_r <= (step_pos.phase != G_IDLE);
      ok_r          <= ok;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ppm_level    = ppm_r;
  assign out_servo_levels = servo_r;
  assign out_frame_active = active_flag_r;
  assign out_packet_ok    = ok_r;

endmodule

@@ hw/rtl/serial_packet_to_ppm_generator.sv @@
// Packet-driven PPM / servo pulse generator.
//
// Input channel (in_valid/in_ready): one request per serial byte
// (in_opcode = 0, in_rx_byte) or per elapsed timer tick (in_opcode = 1).
// Bytes are deframed as FF FF, nine big-endian 16-bit channel times, EE.
// A good packet becomes pending; an idle generator latches it and plays
// one frame, advancing one tick per tick request.
// Output channel (out_valid/out_ready): exactly one result per request,
// giving the PPM and servo pin levels after that request, a frame-active
// flag and a packet-ok flag on the trailer byte that closed a good packet.
// Throughput: one request per cycle unless the result stalls. A request
// passes the front queue, then the registered sequencer stage, to its result.
// A two-entry request queue decouples the input side from the sequencer,
// and the result register holds a stalled result while the queue fills;
// in_ready drops only when both queue entries are occupied.
// Reset (synchronous, rst_n low): parser waits for a header, nothing is
// pending, generator idle, registers back to PPM mode, pre-pulse 2949 and
// sync gap 30966 ticks. Registers sit on the APB port at 0x0, 0x4, 0x8.
module serial_packet_to_ppm_generator
  import spg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ppm_level,
  output logic [7:0]        out_servo_levels,
  output logic              out_frame_active,
  output logic              out_packet_ok,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic       q_full;
  logic       push;
  item_t      push_item;
  logic       q_valid;
  item_t      q_item;
  logic       pop;

  // Register file: written in the access phase, pready tied high
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= MODE_PPM;
      cfg_r.pre  <= PRE_PULSE_RST;
      cfg_r.gap  <= SYNC_GAP_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE: cfg_r.mode <= pwdata[0];
        REG_PRE:  cfg_r.pre  <= pwdata[15:0];
        REG_GAP:  cfg_r.gap  <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE: prdata = {31'd0, cfg_r.mode};
      REG_PRE:  prdata = {16'd0, cfg_r.pre};
      REG_GAP:  prdata = {16'd0, cfg_r.gap};
      default:  prdata = '0;
    endcase
  end

  spg_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  spg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // Deframer and frame sequencer, one request per cycle unless the result stalls
  spg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ppm_level    (out_ppm_level),
    .out_servo_levels (out_servo_levels),
    .out_frame_active (out_frame_active),
    .out_packet_ok    (out_packet_ok)
  );

endmodule

@@ test/serial_packet_to_ppm_generator_test.sv @@
module serial_packet_to_ppm_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spg_pkg::*;

  // One request on the input channel: a received byte or a timer tick
  typedef struct packed {
    logic       op;
    logic [7:0] b;
  } req_t;

  // Pin levels and flags that one request leaves behind
  typedef struct packed {
    logic       ppm;
    logic [7:0] servo;
    logic       active;
    logic       ok;
  } pin_state_t;

  // Packet deframer states
  typedef enum logic [1:0] {
    PARSE_HUNT,
    PARSE_HDR2,
    PARSE_DATA,
    PARSE_TRAILER
  } parse_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        in_opcode  = OP_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        out_ppm_level;
  logic [7:0]  out_servo_levels;
  logic        out_frame_active;
  logic        out_packet_ok;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  serial_packet_to_ppm_generator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ppm_level    (out_ppm_level),
    .out_servo_levels (out_servo_levels),
    .out_frame_active (out_frame_active),
    .out_packet_ok    (out_packet_ok),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stimulus still to be driven, and pin states the block owes us
  req_t       req_q[$];
  pin_state_t pins_due[$];

  // Percent chance per request / per cycle of opening an idle burst
  int idle_pct   = 15;
  int send_hold  = 0;
  int stall_left = 0;

  int errors       = 0;
  int sent         = 0;
  int checked      = 0;
  int packets_ok   = 0;
  int frames_begun = 0;
  int settings     = 1;

  // ---------------------------------------------------------------------
  // Generator shadow: register copies, deframer and frame sequencer
  // ---------------------------------------------------------------------
  logic        m_mode   = MODE_PPM;
  logic [15:0] m_pre    = PRE_PULSE_RST;
  logic [15:0] m_gap    = SYNC_GAP_RST;

  parse_t      parse_st = PARSE_HUNT;
  int          byte_idx = 0;
  chan_vals_t  rx_vals  = '0;       // filled byte by byte, live
  logic        rx_ready = 1'b0;     // a packet with a good trailer waits
  chan_vals_t  play_vals = '0;      // latched at frame start
  gen_phase_t  gphase   = G_IDLE;
  int          slot     = 0;
  logic [15:0] elapsed  = '0;

  // Channels past the end of the packet play as zero
  function automatic logic [15:0] chan_time(int s);
    return (s < PACKET_CHANNELS) ? play_vals[s] : 16'd0;
  endfunction

  // Length of the current phase; registers are read live
  function automatic logic [15:0] span();
    logic [15:0] v;
    v = chan_time(slot);
    case (gphase)
      G_PRE, G_SYNC_PRE: return m_pre;
      G_CHAN:            return (v > m_pre) ? v - m_pre : 16'd0;
      G_SYNC_GAP:        return m_gap;
      G_PWM:             return v;
      default:           return 16'd0;
    endcase
  endfunction

  function automatic void next_phase();
    case (gphase)
      G_PRE: gphase = G_CHAN;
      G_CHAN: begin
        if (slot + 1 < PPM_SLOTS) begin
          slot++;
          gphase = G_PRE;
        end else begin
          slot = 0;
          gphase = G_SYNC_PRE;
        end
      end
      G_SYNC_PRE: gphase = G_SYNC_GAP;
      G_PWM: begin
        if (slot + 1 < SERVO_OUTPUTS) begin
          slot++;
        end else begin
          slot = 0;
          gphase = G_IDLE;
        end
      end
      default: begin
        slot = 0;
        gphase = G_IDLE;
      end
    endcase
  endfunction

  // Zero-length phases never reach the pins: skip them on entry
  function automatic void settle();
    elapsed = '0;
    while (gphase != G_IDLE && span() == 16'd0) next_phase();
  endfunction

  // Deframer; returns 1 when this byte closed a good packet
  function automatic logic take_byte(logic [7:0] b);
    logic good;
    int   ch;
    good = 1'b0;
    case (parse_st)
      PARSE_HUNT: if (b == HDR_BYTE) parse_st = PARSE_HDR2;
      PARSE_HDR2: begin
        if (b == HDR_BYTE) begin
          parse_st = PARSE_DATA;
          byte_idx = 0;
        end else begin
          parse_st = PARSE_HUNT;
        end
      end
      PARSE_DATA: begin
        ch = byte_idx >> 1;
        if (ch < PACKET_CHANNELS) begin
          if (byte_idx % 2 == 0) rx_vals[ch][15:8] = b;
          else rx_vals[ch][7:0] = b;
        end
        // data lands straight in the pending set, so it is no longer whole
        rx_ready = 1'b0;
        if (byte_idx + 1 >= 2 * PACKET_CHANNELS) begin
          parse_st = PARSE_TRAILER;
          byte_idx = 0;
        end else begin
          byte_idx++;
        end
      end
      default: begin
        if (b == TRL_BYTE) begin
          rx_ready = 1'b1;
          good = 1'b1;
        end
        parse_st = PARSE_HUNT;
      end
    endcase
    return good;
  endfunction

  // Pin state after one accepted request
  function automatic pin_state_t predict_pins(logic op, logic [7:0] b);
    pin_state_t r;
    r = '0;
    if (op == OP_BYTE) begin
      r.ok = take_byte(b);
      if (r.ok) packets_ok++;
    end else if (gphase != G_IDLE) begin
      // ticks while idle do nothing
      elapsed = elapsed + 16'd1;
      if (elapsed >= span()) begin
        next_phase();
        settle();
      end
    end
    // frame start is looked at after every request, byte or tick
    if (gphase == G_IDLE && rx_ready) begin
      play_vals = rx_vals;
      rx_ready = 1'b0;
      if (m_mode) gphase = G_PWM;
      else gphase = G_PRE;
      slot = 0;
      frames_begun++;
      settle();
    end
    case (gphase)
      G_PRE, G_CHAN: begin
        r.ppm = (gphase == G_PRE);
        if (slot != SKIPPED_SLOT && slot < SERVO_OUTPUTS) r.servo[slot] = 1'b1;
      end
      G_SYNC_PRE: r.ppm = 1'b1;
      G_PWM: if (slot < SERVO_OUTPUTS) r.servo[slot] = 1'b1;
      default: ;
    endcase
    r.active = (gphase != G_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  function automatic void push_req(logic op, logic [7:0] b);
    req_q.push_back('{op: op, b: b});
  endfunction

  // Ticks carry a random don't-care byte
  function automatic void push_ticks(int n);
    for (int i = 0; i < n; i++) push_req(OP_TICK, 8'($urandom));
  endfunction

  // Header, data_len data bytes, and the trailer only on a full packet
  function automatic void push_packet(chan_vals_t v, int data_len, logic [7:0] trl);
    push_req(OP_BYTE, HDR_BYTE);
    push_req(OP_BYTE, HDR_BYTE);
    for (int i = 0; i < data_len; i++) begin
      if (i % 2 == 0) push_req(OP_BYTE, v[i / 2][15:8]);
      else push_req(OP_BYTE, v[i / 2][7:0]);
    end
    if (data_len == 2 * PACKET_CHANNELS) push_req(OP_BYTE, trl);
  endfunction

  // Played channels stay short so frames finish within a phase; zeros and
  // values near the pre-pulse hit the skipped-phase paths. Channels that are
  // never played get the full 16-bit range.
  function automatic chan_vals_t draw_channels();
    chan_vals_t v;
    int         pick;
    for (int c = 0; c < PACKET_CHANNELS; c++) begin
      pick = $urandom_range(0, 99);
      if (c >= PPM_SLOTS && c >= SERVO_OUTPUTS) v[c] = 16'($urandom);
      else if (pick < 20) v[c] = 16'd0;
      else if (pick < 40) v[c] = 16'($urandom_range(0, 8));
      else v[c] = 16'($urandom_range(1, 24));
    end
    return v;
  endfunction

  // Mostly good packets between runs of ticks; some bad trailers,
  // truncated packets and stray bytes
  task automatic queue_traffic(int n);
    int          added;
    int          pick;
    int          cut;
    logic [7:0]  trl;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        cut = $urandom_range(1, 24);
        push_ticks(cut);
        added += cut;
      end else if (pick < 82) begin
        push_packet(draw_channels(), 2 * PACKET_CHANNELS, TRL_BYTE);
        added += 2 * PACKET_CHANNELS + 3;
      end else if (pick < 90) begin
        do trl = 8'($urandom); while (trl == TRL_BYTE);
        push_packet(draw_channels(), 2 * PACKET_CHANNELS, trl);
        added += 2 * PACKET_CHANNELS + 3;
      end else if (pick < 95) begin
        cut = $urandom_range(0, 2 * PACKET_CHANNELS - 1);
        push_packet(draw_channels(), cut, TRL_BYTE);
        added += cut + 2;
      end else begin
        cut = $urandom_range(1, 3);
        repeat (cut) push_req(OP_BYTE, 8'($urandom));
        added += cut;
      end
    end
  endtask

  // APB write: setup, then access until pready
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE: m_mode = val[0];
      REG_PRE:  m_pre  = val;
      REG_GAP:  m_gap  = val;
      default: ;
    endcase
  endtask

  // Nothing queued, nothing in flight, nothing owed; then a short settle
  task automatic wait_quiet();
    while (req_q.size() != 0 || in_valid || pins_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: hold valid until taken, predict at acceptance
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    req_t r;
    if (in_valid && in_ready) begin
      pins_due.push_back(predict_pins(in_opcode, in_rx_byte));
      sent++;
    end
    if (!in_valid || in_ready) begin
      if (send_hold > 0) begin
        send_hold--;
        in_valid <= 1'b0;
      end else if (rst_n && req_q.size() != 0) begin
        r = req_q.pop_front();
        in_valid   <= 1'b1;
        in_opcode  <= r.op;
        in_rx_byte <= r.b;
        if ($urandom_range(0, 99) < idle_pct) send_hold = $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random backpressure, compare every result in order
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pin_state_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pins_due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = pins_due.pop_front();
        checked++;
        if (out_ppm_level !== want.ppm) begin
          $error("ppm_level: expected %0d, got %0d", want.ppm, out_ppm_level);
          errors++;
        end
        if (out_servo_levels !== want.servo) begin
          $error("servo_levels: expected %02h, got %02h", want.servo, out_servo_levels);
          errors++;
        end
        if (out_frame_active !== want.active) begin
          $error("frame_active: expected %0d, got %0d", want.active, out_frame_active);
          errors++;
        end
        if (out_packet_ok !== want.ok) begin
          $error("packet_ok: expected %0d, got %0d", want.ok, out_packet_ok);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < idle_pct) stall_left = $urandom_range(1, 10);
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    chan_vals_t  dv;
    logic        p_mode [9];
    logic [15:0] p_pre  [9];
    logic [15:0] p_gap  [9];
    int          p_idle [9];

    p_mode = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    p_pre  = '{16'd3, 16'd2, 16'd0, 16'hFFFF, 16'd2, 16'd0, 16'd0,
               16'd4, 16'd1};
    p_gap  = '{16'd5, 16'd0, 16'd7, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0,
               16'd3, 16'd2};
    p_idle = '{15, 30, 5, 15, 0, 30, 15, 5, 0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, on reset register values: idle tick, broken preamble,
    // then a full packet whose channels hold zero, small and extreme values.
    // With the long reset pre-pulse every channel phase collapses, and the
    // frame begins on the trailer byte itself.
    dv    = '0;
    dv[1] = 16'h0001;
    dv[2] = 16'h0020;
    dv[3] = 16'h0003;
    dv[4] = 16'h0010;
    dv[6] = 16'h0005;
    dv[7] = 16'h0006;
    dv[8] = 16'hFFFF;
    push_ticks(1);
    push_req(OP_BYTE, HDR_BYTE);
    push_req(OP_BYTE, 8'h00);
    push_packet(dv, 2 * PACKET_CHANNELS, TRL_BYTE);
    push_ticks(2);
    wait_quiet();

    // Random phases. Registers change only while the channel is quiet, but
    // often in mid-frame: durations are live, mode waits for the next frame.
    // Pre-pulse and gap at 0xFFFF park the frame until a later setting
    // shortens the phase; zero pre-pulse drops every pre-pulse.
    for (int p = 0; p < 9; p++) begin
      // the last setting also runs with no idling on either side
      if (p == 8) p_pre[p] = 16'd1;
      if (p == 6) begin
        p_pre[p] = 16'($urandom_range(1, 8));
        p_gap[p] = 16'($urandom_range(0, 12));
      end
      write_reg(REG_MODE, 16'(p_mode[p]));
      write_reg(REG_PRE, p_pre[p]);
      write_reg(REG_GAP, p_gap[p]);
      settings++;
      idle_pct = p_idle[p];
      queue_traffic(215);
      wait_quiet();
    end

    $display("tb: %0d requests checked as %0d results over %0d register settings",
             sent, checked, settings);
    $display("tb: %0d packets accepted, %0d frames started", packets_ok, frames_begun);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far past the slowest legal run
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
